@@ sv/fdr_pkg.sv @@
// Shared types and constants for the firmware download receiver.
// No dependencies.
`default_nettype none
package fdr_pkg;
    localparam int CHUNK_BYTES = 256;
    localparam int CIDX_W = $clog2(CHUNK_BYTES);
    localparam int CCNT_W = $clog2(CHUNK_BYTES + 1);
    localparam int WIDX_W = (CIDX_W > 2) ? CIDX_W - 2 : 1;
    localparam int QDEPTH = 4;
    localparam int QIDX_W = 2;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [1:0] K_START = 2'd0;
    localparam logic [1:0] K_BYTE  = 2'd1;
    localparam logic [1:0] K_ERASE = 2'd2;
    localparam logic [1:0] K_WRITE = 2'd3;

    localparam logic [2:0] R_READY  = 3'd0;
    localparam logic [2:0] R_ACK    = 3'd1;
    localparam logic [2:0] R_NACK   = 3'd2;
    localparam logic [2:0] R_ERASE  = 3'd3;
    localparam logic [2:0] R_WORD   = 3'd4;
    localparam logic [2:0] R_VERIFY = 3'd5;

    localparam logic [1:0] CFG_STAGING = 2'd0;
    localparam logic [1:0] CFG_FACTORY = 2'd1;
    localparam logic [1:0] CFG_RETRY   = 2'd2;

    // command from the front to the back
    typedef enum logic [2:0] {
        C_SIMPLE = 3'b001,  // one response
        C_BURST  = 3'b010,  // write words of the buffered chunk
        C_ACKVER = 3'b100   // ACK then verify
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [2:0]  resp;
        logic        aborted;
        logic [24:0] size;
        logic [31:0] crc;
        logic [23:0] offset;
        logic [CCNT_W-1:0] len;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  response;
        logic [31:0] write_word;
        logic [23:0] write_offset;
        logic [24:0] image_size;
        logic [31:0] image_crc;
        logic        last;
        logic        aborted;
    } t_result;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction
endpackage
`default_nettype wire

@@ sv/fdr_ram.sv @@
// Generic single write, single registered read RAM.
// No dependencies.
`default_nettype none
module fdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ sv/fdr_front.sv @@
// Front end: session protocol, header parse, chunk CRC, chunk buffer writes.
// Depends on fdr_pkg.
`default_nettype none
module fdr_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [24:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic        i_tf,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_ok,
    output logic             o_cmd_valid,
    output fdr_pkg::t_cmd    o_cmd,
    input  wire logic        i_cmd_space,
    input  wire logic        i_burst_busy,
    output logic             o_buf_we,
    output logic [fdr_pkg::CIDX_W-1:0] o_buf_addr,
    output logic [7:0]       o_buf_data
);
    typedef enum logic [5:0] {
        P_IDLE = 6'b000001, P_HEADER = 6'b000010, P_ERASE = 6'b000100,
        P_DATA = 6'b001000, P_CRC = 6'b010000, P_WRITE = 6'b100000
    } t_phase;

    t_phase r_phase, n_phase;
    logic [24:0] r_stg, r_fac;
    logic [3:0]  r_rlim;
    logic        r_tf, n_tf;
    logic [2:0]  r_hc, n_hc;
    logic [31:0] r_size, n_size, r_crc32, n_crc32;
    logic [24:0] r_rem, n_rem;
    logic [fdr_pkg::CCNT_W-1:0] r_cc, n_cc;
    logic [15:0] r_rcrc, n_rcrc, r_xcrc, n_xcrc;
    logic [3:0]  r_retry, n_retry;
    logic [23:0] r_off, n_off;
    logic [fdr_pkg::CCNT_W-1:0] w_len;
    logic [24:0] w_lim;
    logic [3:0]  w_rnext;
    logic        w_acc;

    assign w_len = (r_rem > 25'(fdr_pkg::CHUNK_BYTES)) ?
                   fdr_pkg::CCNT_W'(fdr_pkg::CHUNK_BYTES) : fdr_pkg::CCNT_W'(r_rem);
    assign w_lim = r_tf ? r_fac : r_stg;
    assign w_rnext = r_retry + 4'd1;
    // a burst still reading the buffer blocks new chunk bytes
    assign o_ready = i_cmd_space && !(i_burst_busy && r_phase == P_DATA);
    assign w_acc = i_valid && o_ready;
    assign o_buf_we = w_acc && i_kind == fdr_pkg::K_BYTE && r_phase == P_DATA;
    assign o_buf_addr = r_cc[fdr_pkg::CIDX_W-1:0];
    assign o_buf_data = i_byte;

    // classify the accepted item
    always_comb begin
        n_phase = r_phase; n_tf = r_tf; n_hc = r_hc; n_size = r_size;
        n_crc32 = r_crc32; n_rem = r_rem; n_cc = r_cc; n_rcrc = r_rcrc;
        n_xcrc = r_xcrc; n_retry = r_retry; n_off = r_off;
        o_cmd_valid = 1'b0;
        o_cmd = '{kind: fdr_pkg::C_SIMPLE, resp: fdr_pkg::R_ACK, aborted: 1'b0,
                  size: '0, crc: '0, offset: '0, len: '0};
        if (w_acc) begin
            case (i_kind)
                fdr_pkg::K_START: begin
                    n_tf = i_tf; n_phase = P_HEADER; n_hc = '0; n_size = '0;
                    n_crc32 = '0; n_rem = '0; n_cc = '0; n_rcrc = fdr_pkg::CRC_INIT;
                    n_xcrc = '0; n_retry = '0; n_off = '0;
                    o_cmd_valid = 1'b1; o_cmd.resp = fdr_pkg::R_READY;
                end
                fdr_pkg::K_BYTE: begin
                    case (r_phase)
                        P_HEADER: begin
                            if (!r_hc[2]) n_size[r_hc[1:0]*8 +: 8] = i_byte;
                            else n_crc32[r_hc[1:0]*8 +: 8] = i_byte;
                            n_hc = r_hc + 3'd1;
                            if (r_hc == 3'd7) begin
                                o_cmd_valid = 1'b1;
                                if (n_size == '0 || n_size > {7'd0, w_lim}) begin
                                    n_phase = P_IDLE;
                                    o_cmd.resp = fdr_pkg::R_NACK; o_cmd.aborted = 1'b1;
                                end else begin
                                    n_phase = P_ERASE;
                                    o_cmd.resp = fdr_pkg::R_ERASE;
                                    o_cmd.size = n_size[24:0];
                                end
                            end
                        end
                        P_DATA: begin
                            n_rcrc = fdr_pkg::crc16_byte(r_rcrc, i_byte);
                            n_cc = r_cc + 1'b1;
                            if (n_cc >= w_len) begin
                                n_phase = P_CRC; n_hc = '0; n_xcrc = '0;
                            end
                        end
                        P_CRC: begin
                            if (r_hc == '0) begin
                                n_xcrc = {8'd0, i_byte}; n_hc = 3'd1;
                            end else begin
                                n_hc = '0;
                                o_cmd_valid = 1'b1;
                                if ({i_byte, r_xcrc[7:0]} == r_rcrc) begin
                                    n_retry = '0; n_phase = P_WRITE;
                                    o_cmd.kind = fdr_pkg::C_BURST;
                                    o_cmd.resp = fdr_pkg::R_WORD;
                                    o_cmd.offset = r_off; o_cmd.len = w_len;
                                end else begin
                                    n_retry = w_rnext;
                                    o_cmd.resp = fdr_pkg::R_NACK;
                                    if (w_rnext >= r_rlim) begin
                                        n_phase = P_IDLE; o_cmd.aborted = 1'b1;
                                    end else begin
                                        n_phase = P_DATA; n_cc = '0;
                                        n_rcrc = fdr_pkg::CRC_INIT; n_xcrc = '0;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                fdr_pkg::K_ERASE: begin
                    if (r_phase == P_ERASE) begin
                        o_cmd_valid = 1'b1;
                        if (!i_ok) begin
                            n_phase = P_IDLE;
                            o_cmd.resp = fdr_pkg::R_NACK; o_cmd.aborted = 1'b1;
                        end else begin
                            n_rem = r_size[24:0]; n_off = '0; n_retry = '0;
                            n_cc = '0; n_hc = '0; n_rcrc = fdr_pkg::CRC_INIT;
                            n_xcrc = '0; n_phase = P_DATA;
                        end
                    end
                end
                default: begin
                    if (r_phase == P_WRITE) begin
                        o_cmd_valid = 1'b1;
                        if (!i_ok) begin
                            n_phase = P_IDLE;
                            o_cmd.resp = fdr_pkg::R_NACK; o_cmd.aborted = 1'b1;
                        end else begin
                            n_off = r_off + 24'(w_len);
                            n_rem = r_rem - 25'(w_len);
                            if (n_rem == '0) begin
                                n_phase = P_IDLE;
                                o_cmd.kind = fdr_pkg::C_ACKVER;
                                o_cmd.size = r_size[24:0]; o_cmd.crc = r_crc32;
                            end else begin
                                n_cc = '0; n_hc = '0; n_rcrc = fdr_pkg::CRC_INIT;
                                n_xcrc = '0; n_phase = P_DATA;
                            end
                        end
                    end
                end
            endcase
        end
    end

    // hold session state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE; r_tf <= 1'b0; r_hc <= '0; r_size <= '0; r_crc32 <= '0;
            r_rem <= '0; r_cc <= '0; r_rcrc <= fdr_pkg::CRC_INIT; r_xcrc <= '0;
            r_retry <= '0; r_off <= '0;
            r_stg <= 25'd393216; r_fac <= 25'd524288; r_rlim <= 4'd5;
        end else begin
            r_phase <= n_phase; r_tf <= n_tf; r_hc <= n_hc; r_size <= n_size;
            r_crc32 <= n_crc32; r_rem <= n_rem; r_cc <= n_cc; r_rcrc <= n_rcrc;
            r_xcrc <= n_xcrc; r_retry <= n_retry; r_off <= n_off;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fdr_pkg::CFG_STAGING: r_stg <= i_cfg_data;
                    fdr_pkg::CFG_FACTORY: r_fac <= i_cfg_data;
                    fdr_pkg::CFG_RETRY:   r_rlim <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_buf_we |-> !i_burst_busy) else $error("buffer written during burst");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> i_cmd_space) else $error("command into full queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == P_DATA |-> r_cc < w_len) else $error("chunk count overrun");
endmodule
`default_nettype wire

@@ sv/fdr_back.sv @@
// Back end: command queue, chunk buffer reads, result output register.
// Depends on fdr_pkg and fdr_ram.
`default_nettype none
module fdr_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  wire fdr_pkg::t_cmd i_cmd,
    output logic             o_cmd_space,
    output logic             o_burst_busy,
    input  wire logic        i_buf_we,
    input  wire logic [fdr_pkg::CIDX_W-1:0] i_buf_addr,
    input  wire logic [7:0]  i_buf_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output fdr_pkg::t_result o_res
);
    fdr_pkg::t_cmd r_q [fdr_pkg::QDEPTH];
    logic [fdr_pkg::QIDX_W-1:0] r_wp, r_rp;
    logic [fdr_pkg::QIDX_W:0] r_cnt;
    fdr_pkg::t_cmd w_head;
    logic w_pop, w_emit, w_free, w_fin, w_load;

    // byte-serial word assembly
    logic        r_act, r_second, r_bpend;
    logic [fdr_pkg::CCNT_W:0] r_idx, r_ridx;
    logic [1:0]  r_lane;
    logic        r_rvalid;
    logic [31:0] r_word;
    logic [7:0]  w_rdata;
    logic [fdr_pkg::CIDX_W-1:0] w_raddr;

    assign w_head = r_q[r_rp];
    assign o_cmd_space = r_cnt < (fdr_pkg::QIDX_W+1)'(fdr_pkg::QDEPTH - 1);
    assign w_free = !o_valid || i_ready;
    // a queued or running burst still owns the chunk buffer
    assign o_burst_busy = r_bpend;

    assign w_emit = r_rvalid && r_lane == 2'd3;
    assign w_fin = r_act && w_emit && w_free &&
                   ((r_ridx + 1'b1) >= {1'b0, w_head.len});
    assign w_pop = (r_cnt != '0) && !r_act && w_free && !r_second &&
                   w_head.kind != fdr_pkg::C_BURST;
    assign w_load = (r_second && w_free) || w_pop || (r_act && w_emit && w_free);
    // hold the read address while a finished word waits for the output
    assign w_raddr = (w_emit && !w_free) ? r_ridx[fdr_pkg::CIDX_W-1:0]
                                         : r_idx[fdr_pkg::CIDX_W-1:0];

    fdr_ram #(.WIDTH(8), .DEPTH(fdr_pkg::CHUNK_BYTES)) u_buf (
        .i_clk(i_clk), .i_we(i_buf_we), .i_waddr(i_buf_addr), .i_wdata(i_buf_data),
        .i_raddr(w_raddr), .o_rdata(w_rdata));

    // queue, burst sequencer and output register
    always_ff @(posedge i_clk) begin
        logic [31:0] v;
        logic [7:0]  b;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_act <= 1'b0; r_second <= 1'b0;
            r_rvalid <= 1'b0; o_valid <= 1'b0; r_idx <= '0; r_ridx <= '0; r_lane <= '0;
            r_bpend <= 1'b0;
        end else begin
            o_valid <= w_load || (o_valid && !i_ready);
            if (i_cmd_valid) begin
                r_q[r_wp] <= i_cmd;
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd_valid && i_cmd.kind == fdr_pkg::C_BURST) r_bpend <= 1'b1;
            else if (w_fin) r_bpend <= 1'b0;
            if (r_second && w_free) begin
                // verify request after the final ACK
                r_second <= 1'b0;
                o_res <= '{response: fdr_pkg::R_VERIFY, write_word: '0, write_offset: '0,
                           image_size: w_head.size, image_crc: w_head.crc,
                           last: 1'b0, aborted: 1'b0};
                r_rp <= r_rp + 1'b1;
            end else if (w_pop) begin
                o_res <= '{response: w_head.kind == fdr_pkg::C_ACKVER ? fdr_pkg::R_ACK
                                                                       : w_head.resp,
                           write_word: '0, write_offset: '0,
                           image_size: (w_head.kind == fdr_pkg::C_ACKVER) ? '0
                                                                          : w_head.size,
                           image_crc: '0,
                           last: 1'b0, aborted: w_head.aborted};
                if (w_head.kind == fdr_pkg::C_ACKVER) r_second <= 1'b1;
                else r_rp <= r_rp + 1'b1;
            end
            if (!r_act && r_cnt != '0 && w_head.kind == fdr_pkg::C_BURST) begin
                r_act <= 1'b1; r_idx <= '0; r_rvalid <= 1'b0; r_lane <= '0;
            end else if (r_act && !(w_emit && !w_free)) begin
                // read one byte a cycle, pack into the word
                r_ridx <= r_idx; r_rvalid <= !w_fin;
                if (r_rvalid) begin
                    b = (r_ridx < {1'b0, w_head.len}) ? w_rdata : 8'hFF;
                    v = r_word;
                    v[r_lane*8 +: 8] = b;
                    r_word <= v;
                    r_lane <= r_lane + 2'd1;
                    if (r_lane == 2'd3) begin
                        o_res <= '{response: fdr_pkg::R_WORD, write_word: v,
                                   write_offset: w_head.offset + 24'(r_ridx - 2'd3),
                                   image_size: '0, image_crc: '0,
                                   last: w_fin, aborted: 1'b0};
                        if (w_fin) begin
                            r_act <= 1'b0; r_rp <= r_rp + 1'b1;
                        end
                    end
                end
                r_idx <= r_idx + 1'b1;
            end
            r_cnt <= r_cnt + (i_cmd_valid ? 1'b1 : 1'b0)
                     - (((r_second && w_free) || (w_pop && w_head.kind != fdr_pkg::C_ACKVER)
                        || w_fin) ? 1'b1 : 1'b0);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (fdr_pkg::QIDX_W+1)'(fdr_pkg::QDEPTH)) else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> !r_act) else $error("verify during burst");
endmodule
`default_nettype wire

@@ sv/firmware_download_receiver.sv @@
// Top level of the firmware download receiver.
// Depends on fdr_pkg, fdr_front, fdr_back, fdr_ram.
//
// Accepts one item a cycle unless held off: start, link byte, erase status or
// write status. A verified chunk of N bytes leaves as ceil(N/4) write words, as
// the back end reads the 256-byte chunk buffer one byte per cycle, when the
// output is free, through its single read port; while that burst runs, new
// chunk bytes are held off. Other items give at most two results, one per
// free output cycle, through a four-entry command queue and an output register.
`default_nettype none
module firmware_download_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [24:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // kind[1:0] data_byte[9:2] status_ok[10]
    input  wire logic        s_axis_tuser,  // target_factory
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // response[2:0] write_word[34:3] write_offset[58:35] image_size[83:59]
    // image_crc[115:84] aborted[116]
    output logic [119:0]     m_axis_tdata,
    output logic             m_axis_tlast
);
    fdr_pkg::t_cmd    w_cmd;
    fdr_pkg::t_result w_res;
    logic w_cmd_valid, w_space, w_busy, w_bwe;
    logic [fdr_pkg::CIDX_W-1:0] w_baddr;
    logic [7:0] w_bdata;

    fdr_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_kind(s_axis_tdata[1:0]), .i_tf(s_axis_tuser), .i_byte(s_axis_tdata[9:2]),
        .i_ok(s_axis_tdata[10]), .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd),
        .i_cmd_space(w_space), .i_burst_busy(w_busy), .o_buf_we(w_bwe),
        .o_buf_addr(w_baddr), .o_buf_data(w_bdata));

    fdr_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_space(w_space), .o_burst_busy(w_busy), .i_buf_we(w_bwe),
        .i_buf_addr(w_baddr), .i_buf_data(w_bdata), .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready), .o_res(w_res));

    // pack the result beat
    assign m_axis_tdata = {3'd0, w_res.aborted, w_res.image_crc, w_res.image_size,
                           w_res.write_offset, w_res.write_word, w_res.response};
    assign m_axis_tlast = w_res.last;
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for firmware_download_receiver: directed tests, then random sessions.
// Depends on fdr_pkg and the receiver RTL; predicts results and checks each output beat.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_idx = '0;
    logic [24:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata = '0;  // kind[1:0] data_byte[9:2] status_ok[10]
    logic         s_axis_tuser = 1'b0;  // target_factory
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // response[2:0] write_word[34:3] write_offset[58:35] image_size[83:59]
    // image_crc[115:84] aborted[116]
    logic [119:0] m_axis_tdata;
    logic         m_axis_tlast;

    firmware_download_receiver dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    typedef enum logic [2:0] {
        P_IDLE, P_HEADER, P_ERASE, P_DATA, P_CRC, P_WRITE
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic       factory;
        logic [7:0] data;
        logic       ok;
    } t_item;

    // receiver model state
    logic [24:0] lim_staging, lim_factory;
    logic [3:0]  lim_retry;
    t_phase      phase;
    logic        to_factory;
    logic [2:0]  hdr_cnt;
    logic [31:0] img_size, img_crc;
    logic [24:0] remaining;
    logic [7:0]  chunk_buf [256];
    logic [8:0]  chunk_cnt;
    logic [15:0] crc_run, crc_rx;
    logic [3:0]  retries;
    logic [23:0] slot_off;

    fdr_pkg::t_result expected_q [$];
    int      errors = 0;
    int      n_sent = 0;
    longint  cycles = 0;
    bit      quiet = 0;  // no idling stretch

    function automatic fdr_pkg::t_result make_res(logic [2:0] r, logic ab);
        fdr_pkg::t_result x;
        x = '0;
        x.response = r;
        x.aborted = ab;
        return x;
    endfunction

    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) v = v[15] ? ((v << 1) ^ 16'h1021) : (v << 1);
        return v;
    endfunction

    function automatic logic [24:0] cur_len();
        return (remaining > 25'd256) ? 25'd256 : remaining;
    endfunction

    task automatic model_reset();
        lim_staging = 25'd393216; lim_factory = 25'd524288; lim_retry = 4'd5;
        phase = P_IDLE; to_factory = 0; hdr_cnt = 0; img_size = 0; img_crc = 0;
        remaining = 0; chunk_cnt = 0; crc_run = 16'hFFFF; crc_rx = 0;
        retries = 0; slot_off = 0;
    endtask

    task automatic begin_chunk();
        chunk_cnt = 0; hdr_cnt = 0; crc_run = 16'hFFFF; crc_rx = 0;
    endtask

    // advance the model by one accepted item and queue its results
    task automatic predict_item(t_item it);
        logic [31:0] lim, n, words, v;
        fdr_pkg::t_result r;
        case (it.kind)
            fdr_pkg::K_START: begin
                to_factory = it.factory; phase = P_HEADER; hdr_cnt = 0;
                img_size = 0; img_crc = 0; remaining = 0; chunk_cnt = 0;
                crc_run = 16'hFFFF; crc_rx = 0; retries = 0; slot_off = 0;
                expected_q.push_back(make_res(fdr_pkg::R_READY, 0));
            end
            fdr_pkg::K_BYTE: begin
                if (phase == P_HEADER) begin
                    if (hdr_cnt < 4) img_size |= 32'(it.data) << (hdr_cnt[1:0] * 8);
                    else img_crc |= 32'(it.data) << (hdr_cnt[1:0] * 8);
                    hdr_cnt = hdr_cnt + 1;
                    if (hdr_cnt == 0) begin
                        lim = to_factory ? lim_factory : lim_staging;
                        if (img_size == 0 || img_size > lim) begin
                            phase = P_IDLE;
                            expected_q.push_back(make_res(fdr_pkg::R_NACK, 1));
                        end else begin
                            phase = P_ERASE;
                            r = make_res(fdr_pkg::R_ERASE, 0);
                            r.image_size = img_size[24:0];
                            expected_q.push_back(r);
                        end
                    end
                end else if (phase == P_DATA) begin
                    chunk_buf[chunk_cnt[7:0]] = it.data;
                    crc_run = crc_step(crc_run, it.data);
                    chunk_cnt++;
                    if (25'(chunk_cnt) >= cur_len()) begin
                        phase = P_CRC; hdr_cnt = 0; crc_rx = 0;
                    end
                end else if (phase == P_CRC) begin
                    if (hdr_cnt == 0) begin
                        crc_rx = {8'h00, it.data}; hdr_cnt = 1;
                    end else begin
                        crc_rx[15:8] = it.data; hdr_cnt = 0;
                        if (crc_rx == crc_run) begin
                            n = 32'(cur_len()); words = (n + 3) / 4; retries = 0;
                            for (int w = 0; w < words; w++) begin
                                v = 0;
                                for (int j = 0; j < 4; j++)
                                    v |= 32'((w*4+j < n) ? chunk_buf[(w*4+j) & 255] : 8'hFF)
                                         << (j*8);
                                r = make_res(fdr_pkg::R_WORD, 0);
                                r.write_word = v;
                                r.write_offset = slot_off + 24'(w*4);
                                r.last = (w + 1 == words);
                                expected_q.push_back(r);
                            end
                            phase = P_WRITE;
                        end else begin
                            retries = retries + 1;
                            if (retries >= lim_retry) begin
                                phase = P_IDLE;
                                expected_q.push_back(make_res(fdr_pkg::R_NACK, 1));
                            end else begin
                                begin_chunk(); phase = P_DATA;
                                expected_q.push_back(make_res(fdr_pkg::R_NACK, 0));
                            end
                        end
                    end
                end
            end
            fdr_pkg::K_ERASE: if (phase == P_ERASE) begin
                if (!it.ok) begin
                    phase = P_IDLE;
                    expected_q.push_back(make_res(fdr_pkg::R_NACK, 1));
                end else begin
                    remaining = img_size[24:0]; slot_off = 0; retries = 0;
                    begin_chunk(); phase = P_DATA;
                    expected_q.push_back(make_res(fdr_pkg::R_ACK, 0));
                end
            end
            default: if (phase == P_WRITE) begin
                if (!it.ok) begin
                    phase = P_IDLE;
                    expected_q.push_back(make_res(fdr_pkg::R_NACK, 1));
                end else begin
                    n = 32'(cur_len());
                    slot_off = slot_off + n[23:0];
                    remaining = remaining - n[24:0];
                    expected_q.push_back(make_res(fdr_pkg::R_ACK, 0));
                    if (remaining == 0) begin
                        phase = P_IDLE;
                        r = make_res(fdr_pkg::R_VERIFY, 0);
                        r.image_size = img_size[24:0];
                        r.image_crc = img_crc;
                        expected_q.push_back(r);
                    end else begin
                        begin_chunk(); phase = P_DATA;
                    end
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string msg);
        errors++;
        $display("MISMATCH @%0d: %s", cycles, msg);
    endtask

    // output side: random stall, compare every accepted beat
    always @(posedge i_clk) begin
        fdr_pkg::t_result got, want;
        cycles <= cycles + 1;
        if (i_rst_n) m_axis_tready <= quiet || ($urandom_range(99) >= 7);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '0;
            got.response = m_axis_tdata[2:0];
            got.write_word = m_axis_tdata[34:3];
            got.write_offset = m_axis_tdata[58:35];
            got.image_size = m_axis_tdata[83:59];
            got.image_crc = m_axis_tdata[115:84];
            got.aborted = m_axis_tdata[116];
            got.last = m_axis_tlast;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected response %0d", got.response));
            end else begin
                want = expected_q.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("got %h want %h", got, want));
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 2000000) begin
            $display("** firmware_download_receiver: FAILED **");
            $finish;
        end
    end

    // drive one item, with random idle before it, until accepted
    task automatic send_item(t_item it);
        while (!quiet && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, it.ok, it.data, it.kind};
        s_axis_tuser <= it.factory;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_item(it);
        n_sent++;
    endtask

    function automatic t_item mk(logic [1:0] k, logic f, logic [7:0] d, logic ok);
        t_item it;
        it.kind = k; it.factory = f; it.data = d; it.ok = ok;
        return it;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [24:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            fdr_pkg::CFG_STAGING: lim_staging = val;
            fdr_pkg::CFG_FACTORY: lim_factory = val;
            default:              lim_retry = val[3:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_header(logic f, logic [31:0] sz, logic [31:0] crc);
        send_item(mk(fdr_pkg::K_START, f, 8'($urandom), 1'($urandom)));
        for (int i = 0; i < 4; i++) send_item(mk(fdr_pkg::K_BYTE, 0, sz[i*8 +: 8], 0));
        for (int i = 0; i < 4; i++) send_item(mk(fdr_pkg::K_BYTE, 0, crc[i*8 +: 8], 0));
    endtask

    // one chunk with a good or bad trailer; model is in the data phase
    task automatic send_chunk(bit good);
        logic [15:0] c;
        int n;
        c = 16'hFFFF;
        n = int'(cur_len());
        for (int i = 0; i < n; i++) begin
            t_item it;
            it = mk(fdr_pkg::K_BYTE, 1'($urandom), 8'($urandom), 1'($urandom));
            c = crc_step(c, it.data);
            send_item(it);
        end
        if (!good) c = c ^ 16'(1 << $urandom_range(15));
        send_item(mk(fdr_pkg::K_BYTE, 0, c[7:0], 0));
        send_item(mk(fdr_pkg::K_BYTE, 0, c[15:8], 0));
    endtask

    // random session: small images, mostly well formed
    task automatic random_session();
        logic [31:0] sz;
        sz = ($urandom_range(9) == 0) ? 32'($urandom_range(300)) : 32'($urandom_range(1, 20));
        send_header(1'($urandom), sz, $urandom);
        if ($urandom_range(19) == 0)
            send_item(mk(2'($urandom), 1'($urandom), 8'($urandom), 1'($urandom)));
        if (phase != P_ERASE) return;
        send_item(mk(fdr_pkg::K_ERASE, 0, 8'($urandom), $urandom_range(15) != 0));
        while (phase == P_DATA) begin
            send_chunk($urandom_range(5) != 0);
            if (phase == P_WRITE)
                send_item(mk(fdr_pkg::K_WRITE, 0, 8'($urandom), $urandom_range(15) != 0));
            if ($urandom_range(29) == 0)
                send_item(mk(2'($urandom), 1'($urandom), 8'($urandom), 1'($urandom)));
        end
    endtask

    t_item            dir_items [$];
    bit               dir_chk   [$];
    fdr_pkg::t_result dir_want  [$];

    initial begin
        t_item   it;
        int      k;
        model_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: ignored items, start, bad sizes
        dir_items = '{mk(fdr_pkg::K_BYTE, 0, 8'hFF, 1), mk(fdr_pkg::K_ERASE, 0, 0, 1),
                      mk(fdr_pkg::K_WRITE, 0, 0, 1),
                      mk(fdr_pkg::K_START, 1, 8'h00, 0),
                      mk(fdr_pkg::K_BYTE, 0, 0, 0), mk(fdr_pkg::K_BYTE, 0, 0, 0),
                      mk(fdr_pkg::K_BYTE, 0, 0, 0), mk(fdr_pkg::K_BYTE, 0, 0, 0),
                      mk(fdr_pkg::K_BYTE, 0, 8'hFF, 0), mk(fdr_pkg::K_BYTE, 0, 8'hFF, 0),
                      mk(fdr_pkg::K_BYTE, 0, 8'hFF, 0), mk(fdr_pkg::K_BYTE, 0, 8'hFF, 0),
                      mk(fdr_pkg::K_START, 0, 8'hFF, 1),
                      mk(fdr_pkg::K_BYTE, 0, 8'hFF, 0), mk(fdr_pkg::K_BYTE, 0, 8'hFF, 0),
                      mk(fdr_pkg::K_BYTE, 0, 8'hFF, 0), mk(fdr_pkg::K_BYTE, 0, 8'hFF, 0),
                      mk(fdr_pkg::K_BYTE, 0, 0, 0), mk(fdr_pkg::K_BYTE, 0, 0, 0),
                      mk(fdr_pkg::K_BYTE, 0, 0, 0), mk(fdr_pkg::K_BYTE, 0, 0, 0)};
        // rows with a typed result: both starts and both header ends
        dir_chk = '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 1};
        // READY, NACK aborted (size 0), READY, NACK aborted (huge size)
        dir_want = '{make_res(fdr_pkg::R_READY, 0), make_res(fdr_pkg::R_NACK, 1),
                     make_res(fdr_pkg::R_READY, 0), make_res(fdr_pkg::R_NACK, 1)};
        k = 0;
        foreach (dir_items[i]) begin
            it = dir_items[i];
            send_item(it);
            if (dir_chk[i]) begin
                expected_q[expected_q.size() - 1] = dir_want[k];
                k++;
            end
        end
        drain();

        // erase failure then ignored byte, checked by prediction
        send_header(1, 32'd5, 32'hDEADBEEF);
        send_item(mk(fdr_pkg::K_ERASE, 0, 0, 0));
        send_item(mk(fdr_pkg::K_BYTE, 0, 8'h55, 1));
        drain();

        // retry limit 0, extreme slot limits
        write_reg(fdr_pkg::CFG_RETRY, 25'd0);
        write_reg(fdr_pkg::CFG_STAGING, 25'd0);
        write_reg(fdr_pkg::CFG_FACTORY, 25'd16777216);
        send_header(0, 32'd1, 32'h0);
        send_header(1, 32'd6, 32'h12345678);
        send_item(mk(fdr_pkg::K_ERASE, 0, 0, 1));
        send_chunk(0);
        drain();
        write_reg(fdr_pkg::CFG_RETRY, 25'd15);
        write_reg(fdr_pkg::CFG_STAGING, 25'd300);
        // full 256 byte chunk plus tail, and a bad chunk CRC retry
        send_header(0, 32'd262, 32'hCAFEF00D);
        send_item(mk(fdr_pkg::K_ERASE, 0, 0, 1));
        send_chunk(1);
        send_item(mk(fdr_pkg::K_WRITE, 0, 0, 1));
        send_chunk(0);
        send_chunk(1);
        send_item(mk(fdr_pkg::K_WRITE, 0, 0, 1));
        drain();

        // random part through several settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(fdr_pkg::CFG_RETRY, (ph == 0) ? 25'd1 : 25'($urandom_range(1, 15)));
            write_reg(fdr_pkg::CFG_STAGING,
                      (ph == 3) ? 25'd16777216 : 25'($urandom_range(4, 300)));
            write_reg(fdr_pkg::CFG_FACTORY, 25'($urandom_range(0, 300)));
            quiet = (ph == 2);
            do random_session(); while (n_sent < (ph + 1) * 105);
            drain();
        end
        quiet = 0;
        drain();
        if (errors == 0 && expected_q.size() == 0) begin
            $display("** firmware_download_receiver: PASSED **");
        end else begin
            $display("** firmware_download_receiver: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
sv/fdr_pkg.sv
sv/fdr_ram.sv
sv/fdr_front.sv
sv/fdr_back.sv
sv/firmware_download_receiver.sv
bench/testbench.sv
